// ===== rtl/core/mhpq_pkg.sv =====
// shared types and codes of the max-heap priority queue
`default_nettype none

package mhpq_pkg;

    localparam int PRIO_W  = 16;
    localparam int TAG_W   = 16;
    localparam int COUNT_W = 10;

    // item kinds on the input channel
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_FULL     = 2'd2,
        ST_EMPTY    = 2'd3
    } t_status;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } t_entry;

    // result handed from the sift engine to the output register
    typedef struct packed {
        t_status           status;
        logic [PRIO_W-1:0] prio;
        logic [TAG_W-1:0]  tag;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_TOP,
        S_DN_RD,
        S_DN_CMP,
        S_FIN
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/max_heap_priority_queue.sv =====
// max-heap priority queue top level: sift engine and output register
//
// Input channel: i_in_valid / o_in_stall carry one item, i_kind selects insert
// (priority and tag from i_priority_req, i_patient_tag) or removal of the
// highest-priority entry. Output channel: o_out_valid / i_out_stall carry one
// result per item: status, removed priority and tag (zero unless removed),
// and the number of entries held afterwards.
// Entries live in a store of CAPACITY words with one write port and two
// registered read ports; each heap level of a sift takes a read step and a
// compare/write step.
// An insert walks the new entry up from the new leaf; a removal reads the
// root and the last entry together, then walks the last entry down from the
// root; a refused insert or removal goes straight to its result. At most 9
// levels are walked for an insert and 8 for a removal at the default CAPACITY.
// One item is worked on at a time: a new item is accepted only after the
// engine has handed on the result of the last one and returned to idle.
// The output register holds a result while the receiver stalls; the engine
// finishes the next item and waits with it until the register frees up.
// Reset empties the queue and clears the output valid; no clearing pass.
`default_nettype none

module max_heap_priority_queue #(
    parameter int CAPACITY = 512
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic                            i_kind,
    input  wire logic [mhpq_pkg::PRIO_W-1:0]     i_priority_req,
    input  wire logic [mhpq_pkg::TAG_W-1:0]      i_patient_tag,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [1:0]                           o_op_status,
    output logic [mhpq_pkg::PRIO_W-1:0]          o_out_priority,
    output logic [mhpq_pkg::TAG_W-1:0]           o_out_tag,
    output logic [mhpq_pkg::COUNT_W-1:0]         o_entry_count
);
    import mhpq_pkg::*;

    localparam int PW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    logic                res_valid;
    logic                res_take;
    t_result             res;
    logic [PW-1:0]       res_count;

    logic                r_out_valid;
    t_result             r_out;
    logic [COUNT_W-1:0]  r_out_count;

    mhpq_engine #(
        .CAPACITY (CAPACITY),
        .PW       (PW),
        .AW       (AW)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_kind      (i_kind),
        .i_prio      (i_priority_req),
        .i_tag       (i_patient_tag),
        .o_res_valid (res_valid),
        .i_res_take  (res_take),
        .o_res       (res),
        .o_res_count (res_count)
    );

    // load the output register when it is empty or being drained
    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out       <= res;
            r_out_count <= COUNT_W'(res_count);
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_op_status    = r_out.status;
    assign o_out_priority = r_out.prio;
    assign o_out_tag      = r_out.tag;
    assign o_entry_count  = r_out_count;

endmodule

`default_nettype wire

// ===== rtl/core/mhpq_mem.sv =====
// heap entry store: one write port, two registered read ports
`default_nettype none

module mhpq_mem #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  wire logic            i_clk,
    input  wire logic            i_we,
    input  wire logic [AW-1:0]   i_waddr,
    input  wire mhpq_pkg::t_entry i_wdata,
    input  wire logic            i_re,
    input  wire logic [AW-1:0]   i_raddr_a,
    input  wire logic [AW-1:0]   i_raddr_b,
    output mhpq_pkg::t_entry     o_rdata_a,
    output mhpq_pkg::t_entry     o_rdata_b
);
    import mhpq_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata_a;
    t_entry r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read ports, registered: data valid in the cycle after the address with i_re
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ===== rtl/core/mhpq_engine.sv =====
// sift engine: heap count, moving entry and the read-modify-write walk
`default_nettype none

module mhpq_engine #(
    parameter int CAPACITY = 512,
    parameter int PW       = 10,
    parameter int AW       = 9
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic                    i_kind,
    input  wire logic [mhpq_pkg::PRIO_W-1:0] i_prio,
    input  wire logic [mhpq_pkg::TAG_W-1:0]  i_tag,
    output logic                         o_res_valid,
    input  wire logic                    i_res_take,
    output mhpq_pkg::t_result            o_res,
    output logic [PW-1:0]                o_res_count
);
    import mhpq_pkg::*;

    localparam logic [PW-1:0] CAP  = PW'(CAPACITY);
    localparam logic [PW-1:0] ROOT = PW'(1);

    t_state         r_state, n_state;
    logic [PW-1:0]  r_count, n_count;
    logic [PW-1:0]  r_hole,  n_hole;
    t_entry         r_ent,   n_ent;
    t_result        r_res,   n_res;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    t_entry         mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr_a;
    logic [AW-1:0]  mem_raddr_b;
    t_entry         mem_rdata_a;
    t_entry         mem_rdata_b;

    logic [PW:0]    child_pos;
    logic [PW:0]    pick_pos;
    logic           take_right;
    t_entry         child;

    // heap position (root at 1) to store address
    function automatic logic [AW-1:0] pos2idx(input logic [PW:0] pos);
        logic [PW:0] idx;
        idx = pos - 1'b1;
        return idx[AW-1:0];
    endfunction

    mhpq_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (mem_re),
        .i_raddr_a (mem_raddr_a),
        .i_raddr_b (mem_raddr_b),
        .o_rdata_a (mem_rdata_a),
        .o_rdata_b (mem_rdata_b)
    );

    // child selection for sift down
    assign child_pos  = {r_hole, 1'b0};
    assign take_right = (child_pos < {1'b0, r_count}) && (mem_rdata_b.prio > mem_rdata_a.prio);
    assign child      = take_right ? mem_rdata_b : mem_rdata_a;
    assign pick_pos   = child_pos | {{PW{1'b0}}, take_right};

    // state register and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hole <= n_hole;
        r_ent  <= n_ent;
        r_res  <= n_res;
    end

    // next state, memory accesses and handshakes
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_hole      = r_hole;
        n_ent       = r_ent;
        n_res       = r_res;
        mem_we      = 1'b0;
        mem_waddr   = pos2idx({1'b0, r_hole});
        mem_wdata   = r_ent;
        mem_re      = 1'b0;
        mem_raddr_a = pos2idx({1'b0, ROOT});
        mem_raddr_b = pos2idx({1'b0, r_count});
        o_in_stall  = 1'b1;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_res = '{status: ST_INSERTED, prio: '0, tag: '0};
                    if (i_kind == KIND_INSERT) begin
                        if (r_count == CAP) begin
                            n_res.status = ST_FULL;
                            n_state      = S_FIN;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_hole  = r_count + 1'b1;
                            n_ent   = '{prio: i_prio, tag: i_tag};
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                            n_state      = S_FIN;
                        end else begin
                            // fetch root and last entry together
                            mem_re       = 1'b1;
                            n_count      = r_count - 1'b1;
                            n_hole       = ROOT;
                            n_res.status = ST_REMOVED;
                            n_state      = S_DN_TOP;
                        end
                    end
                end
            end

            S_UP_RD: begin
                if (r_hole == ROOT) begin
                    mem_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    mem_re      = 1'b1;
                    mem_raddr_a = pos2idx({2'b00, r_hole[PW-1:1]});
                    n_state     = S_UP_CMP;
                end
            end

            S_UP_CMP: begin
                mem_we = 1'b1;
                if (mem_rdata_a.prio < r_ent.prio) begin
                    // parent moves down into the hole
                    mem_wdata = mem_rdata_a;
                    n_hole    = {1'b0, r_hole[PW-1:1]};
                    n_state   = S_UP_RD;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_DN_TOP: begin
                n_res.prio = mem_rdata_a.prio;
                n_res.tag  = mem_rdata_a.tag;
                n_ent      = mem_rdata_b;
                n_state    = S_DN_RD;
            end

            S_DN_RD: begin
                if (child_pos > {1'b0, r_count}) begin
                    mem_we  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    mem_re      = 1'b1;
                    mem_raddr_a = pos2idx(child_pos);
                    mem_raddr_b = pos2idx(child_pos | {{PW{1'b0}}, 1'b1});
                    n_state     = S_DN_CMP;
                end
            end

            S_DN_CMP: begin
                mem_we = 1'b1;
                if (r_ent.prio >= child.prio) begin
                    n_state = S_FIN;
                end else begin
                    // larger child moves up into the hole
                    mem_wdata = child;
                    n_hole    = pick_pos[PW-1:0];
                    n_state   = S_DN_RD;
                end
            end

            S_FIN: begin
                o_res_valid = 1'b1;
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_res       = r_res;
    assign o_res_count = r_count;

    // count stays within capacity
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("heap count above capacity");

    // an accepted insert on a non-full heap grows the count by one
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_kind == KIND_INSERT && r_count != CAP)
        |=> r_count == PW'($past(r_count) + 1'b1))
        else $error("insert did not grow the count");

    // the hole stays inside the heap during a sift
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UP_RD || r_state == S_UP_CMP || r_state == S_DN_RD
         || r_state == S_DN_CMP) |-> (r_hole != '0 && r_hole <= CAP))
        else $error("sift position out of range");

    // never read and write the same entry in one cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr_a && mem_waddr != mem_raddr_b))
        else $error("read and write collide on one entry");

endmodule

`default_nettype wire
